[hw/rtl/rvex_pkg.sv]
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared constants, opcode codes and types of the integer execute stage.
// ----------------------------------------------------------------------------
package rvex_pkg;

   localparam int XLEN      = 32;
   localparam int IDX_W     = 5;
   localparam int OP_W      = 5;
   localparam int REG_COUNT = 32;
   localparam int RF_ADDR_W = $clog2(REG_COUNT);
   localparam int UPPER_W   = 20;
   localparam int LINK_STEP = 4;

   localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
   localparam logic [OP_W-1:0] OP_SUB   = 5'd1;
   localparam logic [OP_W-1:0] OP_AND   = 5'd2;
   localparam logic [OP_W-1:0] OP_OR    = 5'd3;
   localparam logic [OP_W-1:0] OP_SLT   = 5'd4;
   localparam logic [OP_W-1:0] OP_SLTU  = 5'd5;
   localparam logic [OP_W-1:0] OP_SLL   = 5'd6;
   localparam logic [OP_W-1:0] OP_SRL   = 5'd7;
   localparam logic [OP_W-1:0] OP_SRA   = 5'd8;
   localparam logic [OP_W-1:0] OP_ADDI  = 5'd9;
   localparam logic [OP_W-1:0] OP_SLTI  = 5'd10;
   localparam logic [OP_W-1:0] OP_SLTIU = 5'd11;
   localparam logic [OP_W-1:0] OP_ANDI  = 5'd12;
   localparam logic [OP_W-1:0] OP_ORI   = 5'd13;
   localparam logic [OP_W-1:0] OP_XORI  = 5'd14;
   localparam logic [OP_W-1:0] OP_SLLI  = 5'd15;
   localparam logic [OP_W-1:0] OP_SRLI  = 5'd16;
   localparam logic [OP_W-1:0] OP_SRAI  = 5'd17;
   localparam logic [OP_W-1:0] OP_LUI   = 5'd18;
   localparam logic [OP_W-1:0] OP_AUIPC = 5'd19;
   localparam logic [OP_W-1:0] OP_BEQ   = 5'd20;
   localparam logic [OP_W-1:0] OP_BNE   = 5'd21;
   localparam logic [OP_W-1:0] OP_BLT   = 5'd22;
   localparam logic [OP_W-1:0] OP_BGE   = 5'd23;
   localparam logic [OP_W-1:0] OP_BLTU  = 5'd24;
   localparam logic [OP_W-1:0] OP_BGEU  = 5'd25;
   localparam logic [OP_W-1:0] OP_JAL   = 5'd26;
   localparam logic [OP_W-1:0] OP_JALR  = 5'd27;

   typedef struct packed {
      logic [OP_W-1:0]         opcode;
      logic [IDX_W-1:0]        dest_index;
      logic [XLEN-1:0]         operand_a;
      logic [XLEN-1:0]         operand_b;
      logic signed [XLEN-1:0]  immediate;
      logic [XLEN-1:0]         pc_value;
   } alu_in_type;

   typedef struct packed {
      logic            write_enable;
      logic [XLEN-1:0] write_value;
      logic            redirect;
      logic [XLEN-1:0] target_address;
   } alu_out_type;

   function automatic logic reg_in_range(input logic [IDX_W-1:0] idx);
      return {1'b0, idx} < (IDX_W+1)'(REG_COUNT);
   endfunction

endpackage

[hw/rtl/rvex_req_if.sv]
// ----------------------------------------------------------------------------
// rvex_req_if
// Instruction channel: one decoded instruction per item.
// ----------------------------------------------------------------------------
interface rvex_req_if
   import rvex_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        opcode;
   logic [IDX_W-1:0]       dest_index;
   logic [IDX_W-1:0]       src1_index;
   logic [IDX_W-1:0]       src2_index;
   logic signed [XLEN-1:0] immediate;
   logic [XLEN-1:0]        pc_value;

   modport source (output valid, opcode, dest_index, src1_index, src2_index, immediate,
                   pc_value, input ready);
   modport sink (input valid, opcode, dest_index, src1_index, src2_index, immediate,
                 pc_value, output ready);
endinterface

[hw/rtl/rvex_rsp_if.sv]
// ----------------------------------------------------------------------------
// rvex_rsp_if
// Result channel: write-back and redirect report for one instruction.
// ----------------------------------------------------------------------------
interface rvex_rsp_if
   import rvex_pkg::*;
   ;
   logic            valid;
   logic            ready;
   logic            write_enable;
   logic [XLEN-1:0] write_value;
   logic            redirect;
   logic [XLEN-1:0] target_address;

   modport source (output valid, write_enable, write_value, redirect, target_address,
                   input ready);
   modport sink (input valid, write_enable, write_value, redirect, target_address,
                 output ready);
endinterface

[hw/rtl/rv32i_integer_execute.sv]
// ----------------------------------------------------------------------------
// rv32i_integer_execute
// An accepted instruction is held in the stage-1 registers and the registered
// register-file read, then in the result register, from which it can be taken.
// Throughput: one instruction per cycle while the result side is not stalled,
// with register-file read and execute stages and a forward from the preceding write.
// Reset clears the pipeline and all register valid bits, so every register
// reads as zero until written.
// ----------------------------------------------------------------------------
module rv32i_integer_execute
   import rvex_pkg::*;
(
   input logic        clock,
   input logic        reset,
   rvex_req_if.sink   req_port,
   rvex_rsp_if.source rsp_port
);

   logic                   req_fire;
   logic                   out_free;
   logic                   s1_go;
   logic                   wr_now;
   logic [RF_ADDR_W-1:0]   wr_addr;
   logic [RF_ADDR_W-1:0]   rd_addr_1;
   logic [RF_ADDR_W-1:0]   rd_addr_2;
   logic [XLEN-1:0]        ram_a;
   logic [XLEN-1:0]        ram_b;
   alu_in_type             alu_in;
   alu_out_type            alu_out;

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [OP_W-1:0]        s1_opcode_ff;
   logic [IDX_W-1:0]       s1_dest_ff;
   logic signed [XLEN-1:0] s1_imm_ff;
   logic [XLEN-1:0]        s1_pc_ff;
   logic                   s1_valid1_ff;
   logic                   s1_valid2_ff;
   logic                   s1_fwd1_ff;
   logic                   s1_fwd2_ff;
   logic [XLEN-1:0]        wr_val_ff;
   logic [REG_COUNT-1:0]   rf_valid_ff;
   logic [REG_COUNT-1:0]   rf_valid_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   alu_out_type            rsp_data_ff;

   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign s1_go          = s1_valid_ff && out_free;
   assign req_port.ready = !s1_valid_ff || s1_go;
   assign req_fire       = req_port.valid && req_port.ready;

   assign rd_addr_1 = req_port.src1_index[RF_ADDR_W-1:0];
   assign rd_addr_2 = req_port.src2_index[RF_ADDR_W-1:0];
   assign wr_addr   = s1_dest_ff[RF_ADDR_W-1:0];
   assign wr_now    = s1_go && alu_out.write_enable;

   rvex_ram #(
      .WIDTH(XLEN),
      .DEPTH(REG_COUNT)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wr_now),
      .wr_addr   (wr_addr),
      .wr_data   (alu_out.write_value),
      .rd_en     (req_fire),
      .rd_addr_a (rd_addr_1),
      .rd_addr_b (rd_addr_2),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   always_comb begin
      alu_in.opcode     = s1_opcode_ff;
      alu_in.dest_index = s1_dest_ff;
      alu_in.immediate  = s1_imm_ff;
      alu_in.pc_value   = s1_pc_ff;
      alu_in.operand_a  = s1_fwd1_ff ? wr_val_ff : (s1_valid1_ff ? ram_a : '0);
      alu_in.operand_b  = s1_fwd2_ff ? wr_val_ff : (s1_valid2_ff ? ram_b : '0);
   end

   rvex_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      rf_valid_in = rf_valid_ff;
      if (wr_now) begin
         rf_valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rf_valid_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rf_valid_ff  <= rf_valid_in;
      end
   end

   // A source read in the same cycle as the preceding write misses it in the
   // RAM, so the written value is forwarded instead.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_opcode_ff <= req_port.opcode;
         s1_dest_ff   <= req_port.dest_index;
         s1_imm_ff    <= req_port.immediate;
         s1_pc_ff     <= req_port.pc_value;
         s1_valid1_ff <= rf_valid_ff[rd_addr_1] && reg_in_range(req_port.src1_index);
         s1_valid2_ff <= rf_valid_ff[rd_addr_2] && reg_in_range(req_port.src2_index);
         s1_fwd1_ff   <= wr_now && (s1_dest_ff == req_port.src1_index);
         s1_fwd2_ff   <= wr_now && (s1_dest_ff == req_port.src2_index);
      end
      if (wr_now) begin
         wr_val_ff <= alu_out.write_value;
      end
      if (s1_go) begin
         rsp_data_ff <= alu_out;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.write_enable   = rsp_data_ff.write_enable;
   assign rsp_port.write_value    = rsp_data_ff.write_value;
   assign rsp_port.redirect       = rsp_data_ff.redirect;
   assign rsp_port.target_address = rsp_data_ff.target_address;

endmodule

[hw/rtl/rvex_ram.sv]
// ----------------------------------------------------------------------------
// rvex_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rvex_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[hw/rtl/rvex_alu.sv]
// ----------------------------------------------------------------------------
// rvex_alu
// Combinational execute logic: ALU ops, branch compares, jumps and link.
// ----------------------------------------------------------------------------
module rvex_alu
   import rvex_pkg::*;
(
   input  alu_in_type  alu_in,
   output alu_out_type alu_out
);

   logic [XLEN-1:0] a;
   logic [XLEN-1:0] b;
   logic [XLEN-1:0] imm;
   logic [XLEN-1:0] pc;
   logic [XLEN-1:0] upper;
   logic [XLEN-1:0] link;
   logic [XLEN-1:0] value;
   logic            writes;
   logic            jump;
   logic            dest_ok;

   assign a     = alu_in.operand_a;
   assign b     = alu_in.operand_b;
   assign imm   = $unsigned(alu_in.immediate);
   assign pc    = alu_in.pc_value;
   assign upper = {imm[UPPER_W-1:0], {(XLEN-UPPER_W){1'b0}}};
   assign link  = pc + XLEN'(LINK_STEP);

   always_comb begin
      value  = '0;
      writes = 1'b0;
      jump   = 1'b0;
      unique case (alu_in.opcode)
         OP_ADD:   begin value = a + b; writes = 1'b1; end
         OP_SUB:   begin value = a - b; writes = 1'b1; end
         OP_AND:   begin value = a & b; writes = 1'b1; end
         OP_OR:    begin value = a | b; writes = 1'b1; end
         OP_SLT:   begin value = XLEN'($signed(a) < $signed(b)); writes = 1'b1; end
         OP_SLTU:  begin value = XLEN'(a < b); writes = 1'b1; end
         OP_SLL:   begin value = a << b[4:0]; writes = 1'b1; end
         OP_SRL:   begin value = a >> b[4:0]; writes = 1'b1; end
         OP_SRA:   begin value = $unsigned($signed(a) >>> b[4:0]); writes = 1'b1; end
         OP_ADDI:  begin value = a + imm; writes = 1'b1; end
         OP_SLTI:  begin value = XLEN'($signed(a) < $signed(imm)); writes = 1'b1; end
         OP_SLTIU: begin value = XLEN'(a < imm); writes = 1'b1; end
         OP_ANDI:  begin value = a & imm; writes = 1'b1; end
         OP_ORI:   begin value = a | imm; writes = 1'b1; end
         OP_XORI:  begin value = a ^ imm; writes = 1'b1; end
         OP_SLLI:  begin value = a << imm[4:0]; writes = 1'b1; end
         OP_SRLI:  begin value = a >> imm[4:0]; writes = 1'b1; end
         OP_SRAI:  begin value = $unsigned($signed(a) >>> imm[4:0]); writes = 1'b1; end
         OP_LUI:   begin value = upper; writes = 1'b1; end
         OP_AUIPC: begin value = pc + upper; writes = 1'b1; end
         OP_BEQ:   jump = (a == b);
         OP_BNE:   jump = (a != b);
         OP_BLT:   jump = ($signed(a) < $signed(b));
         OP_BGE:   jump = !($signed(a) < $signed(b));
         OP_BLTU:  jump = (a < b);
         OP_BGEU:  jump = !(a < b);
         OP_JAL:   begin value = link; writes = 1'b1; jump = 1'b1; end
         OP_JALR:  begin value = link; writes = 1'b1; jump = 1'b1; end
         default:  begin value = '0; writes = 1'b0; jump = 1'b0; end
      endcase
   end

   assign dest_ok = (alu_in.dest_index != '0) && reg_in_range(alu_in.dest_index);

   always_comb begin
      alu_out.write_enable   = writes && dest_ok;
      alu_out.write_value    = (writes && dest_ok) ? value : '0;
      alu_out.redirect       = jump;
      alu_out.target_address = '0;
      if (jump) begin
         if (alu_in.opcode == OP_JALR) begin
            alu_out.target_address = (a + imm) & ~XLEN'(1);
         end else begin
            alu_out.target_address = pc + imm;
         end
      end
   end

endmodule

[hw/rtl/rvex_checker.sv]
// ----------------------------------------------------------------------------
// rvex_checker
// Port-level checks of the execute stage, bound to the top level.
// ----------------------------------------------------------------------------
module rvex_checker
   import rvex_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic            rsp_write_enable,
   input logic [XLEN-1:0] rsp_write_value,
   input logic            rsp_redirect,
   input logic [XLEN-1:0] rsp_target_address
);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("Accepted item did not reach the result register in time.");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("Input stalled while the result side was free.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_write_enable)
         && $stable(rsp_write_value) && $stable(rsp_redirect)
         && $stable(rsp_target_address)))
      else $error("Stalled result item changed.");

   a_no_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_redirect) |-> (rsp_target_address == '0))
      else $error("Target shown without a redirect.");

   a_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_enable) |-> (rsp_write_value == '0))
      else $error("Write value shown without a write.");

endmodule

bind rv32i_integer_execute rvex_checker u_rvex_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_port.valid),
   .req_ready          (req_port.ready),
   .rsp_valid          (rsp_port.valid),
   .rsp_ready          (rsp_port.ready),
   .rsp_write_enable   (rsp_port.write_enable),
   .rsp_write_value    (rsp_port.write_value),
   .rsp_redirect       (rsp_port.redirect),
   .rsp_target_address (rsp_port.target_address)
);

[verif/rv32i_integer_execute_check.sv]
// ----------------------------------------------------------------------------
// rv32i_integer_execute_check
// Passive checker for the integer execute stage. It keeps its own copy of the
// architectural register file. For every accepted instruction it computes the
// write-back and redirect report. It compares each accepted result, field by
// field, against the oldest outstanding report.
// ----------------------------------------------------------------------------
module rv32i_integer_execute_check
   import rvex_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rvex_req_if  req_mon,
   rvex_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [XLEN-1:0] arch_regs [REG_COUNT];
   alu_out_type     pending_reports [$];
   alu_out_type     want;
   alu_out_type     seen;
   int              error_total;

   assign mismatch_count = error_total;

   function automatic logic [XLEN-1:0] read_arch(input logic [IDX_W-1:0] idx);
      if (idx == '0 || int'(idx) >= REG_COUNT) begin
         return '0;
      end
      return arch_regs[idx];
   endfunction

   function automatic alu_out_type retire_instruction(
      input logic [OP_W-1:0]  op,
      input logic [IDX_W-1:0] rd,
      input logic [IDX_W-1:0] rs1,
      input logic [IDX_W-1:0] rs2,
      input logic [XLEN-1:0]  imm,
      input logic [XLEN-1:0]  pc
   );
      logic [XLEN-1:0] a;
      logic [XLEN-1:0] b;
      logic [XLEN-1:0] upper;
      logic [XLEN-1:0] value;
      logic [XLEN-1:0] target;
      logic            writes;
      logic            jump;
      alu_out_type     report;
      a      = read_arch(rs1);
      b      = read_arch(rs2);
      upper  = {imm[UPPER_W-1:0], 12'b0};
      value  = '0;
      target = '0;
      writes = 1'b1;
      jump   = 1'b0;
      case (op)
         OP_ADD:   value = a + b;
         OP_SUB:   value = a - b;
         OP_AND:   value = a & b;
         OP_OR:    value = a | b;
         OP_SLT:   value = XLEN'($signed(a) < $signed(b));
         OP_SLTU:  value = XLEN'(a < b);
         OP_SLL:   value = a << b[4:0];
         OP_SRL:   value = a >> b[4:0];
         OP_SRA:   value = $signed(a) >>> b[4:0];
         OP_ADDI:  value = a + imm;
         OP_SLTI:  value = XLEN'($signed(a) < $signed(imm));
         OP_SLTIU: value = XLEN'(a < imm);
         OP_ANDI:  value = a & imm;
         OP_ORI:   value = a | imm;
         OP_XORI:  value = a ^ imm;
         OP_SLLI:  value = a << imm[4:0];
         OP_SRLI:  value = a >> imm[4:0];
         OP_SRAI:  value = $signed(a) >>> imm[4:0];
         OP_LUI:   value = upper;
         OP_AUIPC: value = pc + upper;
         OP_BEQ: begin
            writes = 1'b0;
            jump   = (a == b);
         end
         OP_BNE: begin
            writes = 1'b0;
            jump   = (a != b);
         end
         OP_BLT: begin
            writes = 1'b0;
            jump   = $signed(a) < $signed(b);
         end
         OP_BGE: begin
            writes = 1'b0;
            jump   = !($signed(a) < $signed(b));
         end
         OP_BLTU: begin
            writes = 1'b0;
            jump   = (a < b);
         end
         OP_BGEU: begin
            writes = 1'b0;
            jump   = !(a < b);
         end
         OP_JAL, OP_JALR: begin
            value = pc + XLEN'(LINK_STEP);
            jump  = 1'b1;
         end
         default: writes = 1'b0;
      endcase
      if (jump) begin
         target = (op == OP_JALR) ? ((a + imm) & ~XLEN'(1)) : (pc + imm);
      end
      if (writes && rd != '0 && int'(rd) < REG_COUNT) begin
         arch_regs[rd] = value;
      end else begin
         writes = 1'b0;
         value  = '0;
      end
      report.write_enable   = writes;
      report.write_value    = value;
      report.redirect       = jump;
      report.target_address = target;
      return report;
   endfunction

   task automatic compare_field(input string field, input logic [XLEN-1:0] exp_v,
                                input logic [XLEN-1:0] got_v);
      if (exp_v !== got_v) begin
         error_total++;
         $display("%0t: %s expected %h actual %h", $time, field, exp_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            arch_regs[i] = '0;
         end
         pending_reports.delete();
         error_total = 0;
         outstanding <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.write_enable   = rsp_mon.write_enable;
            seen.write_value    = rsp_mon.write_value;
            seen.redirect       = rsp_mon.redirect;
            seen.target_address = rsp_mon.target_address;
            if (pending_reports.size() == 0) begin
               error_total++;
               $display("%0t: unexpected item expected none actual %h", $time, seen);
            end else begin
               want = pending_reports.pop_front();
               compare_field("write_enable", XLEN'(want.write_enable),
                             XLEN'(seen.write_enable));
               compare_field("write_value", want.write_value, seen.write_value);
               compare_field("redirect", XLEN'(want.redirect), XLEN'(seen.redirect));
               compare_field("target_address", want.target_address,
                             seen.target_address);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_reports = {pending_reports, retire_instruction(
               req_mon.opcode, req_mon.dest_index, req_mon.src1_index,
               req_mon.src2_index, req_mon.immediate, req_mon.pc_value)};
         end
         outstanding <= pending_reports.size();
      end
   end

endmodule

[verif/rv32i_integer_execute_tb.sv]
// ----------------------------------------------------------------------------
// rv32i_integer_execute_tb
// Testbench for the integer execute stage. A directed sequence covers every
// opcode, the operand extremes, register zero, reserved opcodes and untaken
// branches. A long random sequence with register hazards follows. Both
// channels idle at random, with stretches of full rate.
// ----------------------------------------------------------------------------
module rv32i_integer_execute_tb;
   import rvex_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int              RANDOM_ITEMS   = 1100;
   localparam int              IDLE_LIMIT     = 2000;
   localparam int              DRAIN_CYCLES   = 10;
   localparam logic [OP_W-1:0] OP_RSVD_FIRST  = 5'd28;
   localparam logic [OP_W-1:0] OP_RSVD_LAST   = 5'd31;

   logic clock;
   logic reset;
   bit   steady;
   int   mismatch_count;
   int   outstanding;
   int   idle_cycles;

   rvex_req_if req_bus ();
   rvex_rsp_if rsp_bus ();

   rv32i_integer_execute dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   rv32i_integer_execute_check result_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] rd,
                        input logic [IDX_W-1:0] rs1, input logic [IDX_W-1:0] rs2,
                        input logic [XLEN-1:0] imm, input logic [XLEN-1:0] pc);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.dest_index <= rd;
      req_bus.src1_index <= rs1;
      req_bus.src2_index <= rs2;
      req_bus.immediate  <= imm;
      req_bus.pc_value   <= pc;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain_results();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [IDX_W-1:0] pick_index(input bit hazard);
      return hazard ? IDX_W'($urandom_range(0, 3)) : IDX_W'($urandom_range(0, 31));
   endfunction

   function automatic logic [XLEN-1:0] pick_value();
      case ($urandom_range(0, 3))
         0:       return $urandom();
         1:       return XLEN'($urandom_range(0, 4095)) - XLEN'(2048);
         2: begin
            case ($urandom_range(0, 3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return {$urandom_range(0, 31) == 0 ? 27'h7FF_FFFF : 27'h0,
                          5'($urandom_range(0, 31))};
      endcase
   endfunction

   initial begin
      logic [OP_W-1:0] op;
      bit              hazard;
      reset              = 1'b1;
      steady             = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_ADD;
      req_bus.dest_index = '0;
      req_bus.src1_index = '0;
      req_bus.src2_index = '0;
      req_bus.immediate  = '0;
      req_bus.pc_value   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(OP_LUI,   5'd1,  5'd0,  5'd0,  32'h0008_0000, 32'h0);
      issue(OP_LUI,   5'd20, 5'd0,  5'd0,  32'hFFFF_FFFF, 32'h0);
      issue(OP_ADDI,  5'd2,  5'd0,  5'd0,  32'hFFFF_FFFF, 32'h0);
      issue(OP_ADDI,  5'd3,  5'd0,  5'd0,  32'h7FFF_FFFF, 32'h0);
      issue(OP_ADD,   5'd4,  5'd1,  5'd2,  32'h0, 32'h0);
      issue(OP_SUB,   5'd5,  5'd0,  5'd1,  32'h0, 32'h0);
      issue(OP_AND,   5'd6,  5'd2,  5'd3,  32'h0, 32'h0);
      issue(OP_OR,    5'd7,  5'd1,  5'd3,  32'h0, 32'h0);
      issue(OP_SLT,   5'd8,  5'd1,  5'd3,  32'h0, 32'h0);
      issue(OP_SLTU,  5'd9,  5'd1,  5'd3,  32'h0, 32'h0);
      issue(OP_SLL,   5'd10, 5'd2,  5'd3,  32'h0, 32'h0);
      issue(OP_SRL,   5'd11, 5'd1,  5'd2,  32'h0, 32'h0);
      issue(OP_SRA,   5'd12, 5'd1,  5'd2,  32'h0, 32'h0);
      issue(OP_SLTI,  5'd13, 5'd1,  5'd0,  32'hFFFF_FFFF, 32'h0);
      issue(OP_SLTIU, 5'd14, 5'd3,  5'd0,  32'hFFFF_FFFF, 32'h0);
      issue(OP_ANDI,  5'd15, 5'd2,  5'd0,  32'h8000_0000, 32'h0);
      issue(OP_ORI,   5'd16, 5'd0,  5'd0,  32'h8000_0000, 32'h0);
      issue(OP_XORI,  5'd17, 5'd2,  5'd0,  32'hFFFF_FFFF, 32'h0);
      issue(OP_SLLI,  5'd18, 5'd2,  5'd0,  32'hFFFF_FFFF, 32'h0);
      issue(OP_SRLI,  5'd19, 5'd1,  5'd0,  32'h0000_0020, 32'h0);
      issue(OP_SRAI,  5'd21, 5'd1,  5'd0,  32'h0000_001F, 32'h0);
      issue(OP_AUIPC, 5'd22, 5'd0,  5'd0,  32'h000F_FFFF, 32'hFFFF_FFFF);
      issue(OP_BEQ,   5'd23, 5'd0,  5'd0,  32'h7FFF_FFFF, 32'hFFFF_FFFF);
      issue(OP_BNE,   5'd24, 5'd1,  5'd1,  32'h8000_0000, 32'h0000_1000);
      issue(OP_BLT,   5'd0,  5'd1,  5'd3,  32'hFFFF_FFF0, 32'h0000_0100);
      issue(OP_BGE,   5'd0,  5'd1,  5'd3,  32'h0000_0010, 32'h0000_0100);
      issue(OP_BLTU,  5'd0,  5'd1,  5'd3,  32'h0000_0010, 32'h0000_0100);
      issue(OP_BGEU,  5'd0,  5'd1,  5'd3,  32'h0000_0010, 32'h0000_0100);
      issue(OP_JAL,   5'd0,  5'd0,  5'd0,  32'hFFFF_FFF8, 32'hFFFF_FFFC);
      issue(OP_JALR,  5'd31, 5'd1,  5'd0,  32'hFFFF_FFFF, 32'h0);
      issue(OP_JALR,  5'd5,  5'd5,  5'd0,  32'h0000_0003, 32'h0000_0040);
      issue(OP_RSVD_FIRST, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(OP_RSVD_LAST,  5'd30, 5'd1,  5'd2,  32'h1234_5678, 32'h8000_0000);
      issue(OP_ADD,   5'd0,  5'd2,  5'd2,  32'h0, 32'h0);

      req_bus.valid <= 1'b0;
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
         end
         if (n % 200 == 100) begin
            req_bus.valid <= 1'b0;
            drain_results();
         end
         if ($urandom_range(0, 9) == 0) begin
            op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
         end else begin
            op = OP_W'($urandom_range(OP_ADD, OP_JALR));
         end
         hazard = ($urandom_range(0, 2) == 0);
         issue(op, pick_index(hazard), pick_index(hazard), pick_index(hazard),
               pick_value(), $urandom_range(0, 7) == 0 ? pick_value() : $urandom());
      end

      req_bus.valid <= 1'b0;
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
